[hw/rtl/smrs_pkg.sv]
package smrs_pkg;

  // Ring and slot table geometry
  localparam int RING_BYTES = 8192;
  localparam int RING_AW    = $clog2(RING_BYTES);
  localparam int NUM_SLOTS  = 16;
  localparam int SLOT_W     = 4;
  localparam int MAX_MSG    = 64;
  localparam int MSG_CW     = $clog2(MAX_MSG);
  localparam int HEADER_LEN = 8;
  localparam int SEQ_W      = 32;

  localparam logic [31:0] NO_RECORD = 32'hFFFF_FFFF;

  // Opcodes
  localparam logic OP_PUT = 1'b0;
  localparam logic OP_GET = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_STALE = 2'd2;

  // One entry of the slot table memory
  typedef struct packed {
    logic [SEQ_W-1:0]   seq;
    logic [RING_AW-1:0] start;
  } slot_entry_t;

  // One result item
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] read_byte;
    logic       last;
  } result_t;

  // Advance a ring address by a small step, wrapping at the ring end
  function automatic logic [RING_AW-1:0] ring_add(input logic [RING_AW-1:0] a,
                                                  input logic [2:0]         inc);
    logic [RING_AW:0] s;
    s = {1'b0, a} + (RING_AW+1)'(inc);
    if (s >= (RING_AW+1)'(RING_BYTES)) begin
      s = s - (RING_AW+1)'(RING_BYTES);
    end
    return s[RING_AW-1:0];
  endfunction

endpackage

[hw/rtl/smrs_ram.sv]
module smrs_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

[hw/rtl/smrs_out_buf.sv]
module smrs_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  smrs_pkg::result_t item_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              pop_i,
  output smrs_pkg::result_t item_o
);

  smrs_pkg::result_t buf_q [2];
  logic              wr_q, rd_q;
  logic [1:0]        cnt_q;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = buf_q[rd_q];

  // Hold result items until the sink takes them
  always_ff @(posedge clk_i) begin
    if (push_i && ready_o) begin
      buf_q[wr_q] <= item_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && ready_o) begin
        wr_q <= ~wr_q;
      end
      if (pop_i && valid_o) begin
        rd_q <= ~rd_q;
      end
      case ({push_i && ready_o, pop_i && valid_o})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[hw/rtl/slot_mailbox_ring_store.sv]
// Slot mailbox ring store. Puts stream in one byte per item; for the opening item
// of a put (first set) the block accepts it, reads and updates the slot table,
// writes the eight header bytes (sequence number, then previous record pointer,
// low byte first) and then its own byte. Every following byte of an open put is
// written as it is accepted; a zero byte closes the put.
// A get reports an empty slot or an overwritten record as a single result item,
// or streams a message of n result items; its reads go through the single read
// port of the 8 KiB ring memory, which delivers one byte per cycle from a
// registered read. Results go through a two-item output buffer, so a
// stalled sink only holds the sequencer while that buffer is full. The ring
// memory has no reset; a get that reaches ring bytes never written (after an
// unterminated put) returns whatever the memory holds.
module slot_mailbox_ring_store (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // slot[3:0], msg_length[9:4], data_byte[17:10]
  input  logic [1:0]  s_axis_tuser_i,  // opcode[0], first[1]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // read_byte[7:0]
  output logic [1:0]  m_axis_tuser_o,  // status[1:0]
  output logic        m_axis_tlast_o
);

  localparam int AW = smrs_pkg::RING_AW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUT_SLOT,
    ST_PUT_HDR,
    ST_PUT_DATA,
    ST_GET_SLOT,
    ST_GET_SEQ,
    ST_GET_MSG
  } state_e;

  // Input fields
  logic                        in_opcode, in_first;
  logic [smrs_pkg::SLOT_W-1:0] in_slot;
  logic [5:0]                  in_len;
  logic [7:0]                  in_data;
  logic                        accept;

  assign in_opcode = s_axis_tuser_i[0];
  assign in_first  = s_axis_tuser_i[1];
  assign in_slot   = s_axis_tdata_i[3:0];
  assign in_len    = s_axis_tdata_i[9:4];
  assign in_data   = s_axis_tdata_i[17:10];

  // Sequencer state
  state_e                        state_q, state_d;
  logic [smrs_pkg::SLOT_W-1:0]   slot_q, slot_d;
  logic [5:0]                    len_q, len_d;
  logic [7:0]                    data_q, data_d;
  logic [AW-1:0]                 wp_q, wp_d;
  logic                          put_open_q, put_open_d;
  logic [63:0]                   hdr_q, hdr_d;
  logic [2:0]                    cnt_q, cnt_d;
  logic [smrs_pkg::SEQ_W-1:0]    seq_q, seq_d;
  logic [23:0]                   stored_q, stored_d;
  logic [AW-1:0]                 cur_q, cur_d;
  logic [smrs_pkg::MSG_CW-1:0]   n_q, n_d;
  logic [smrs_pkg::NUM_SLOTS-1:0] slot_valid_q, slot_valid_d;

  // Memory ports
  logic                         slot_we;
  logic [smrs_pkg::SLOT_W-1:0]  slot_raddr;
  smrs_pkg::slot_entry_t        slot_wdata, slot_rd;
  logic [$bits(smrs_pkg::slot_entry_t)-1:0] slot_rdata;
  logic                         ring_we;
  logic [AW-1:0]                ring_waddr, ring_raddr;
  logic [7:0]                   ring_wdata, ring_rdata;

  // Output buffer ports
  logic              ob_push, ob_ready;
  smrs_pkg::result_t ob_item, ob_head;

  // Put header arithmetic
  logic [smrs_pkg::SEQ_W-1:0] seq_old, seq_new;
  logic [AW:0]                fit_sum;
  logic                       wrap;
  logic [31:0]                prev;
  logic [31:0]                stored_full;
  logic                       fin;
  logic                       get_active;

  assign slot_rd     = smrs_pkg::slot_entry_t'(slot_rdata);
  assign seq_old     = slot_valid_q[slot_q] ? slot_rd.seq : '0;
  assign seq_new     = seq_old + smrs_pkg::SEQ_W'(1);
  assign fit_sum     = {1'b0, wp_q} + (AW+1)'(len_q) + (AW+1)'(smrs_pkg::HEADER_LEN);
  assign wrap        = (fit_sum >= (AW+1)'(smrs_pkg::RING_BYTES));
  assign stored_full = {ring_rdata, stored_q};
  assign fin         = (ring_rdata == 8'd0) ||
                       (n_q == smrs_pkg::MSG_CW'(smrs_pkg::MAX_MSG - 1));
  assign get_active  = (state_q == ST_GET_SLOT) || (state_q == ST_GET_SEQ) ||
                       (state_q == ST_GET_MSG);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    if (wrap) begin
      prev = 32'd0;
    end else if (slot_valid_q[slot_q]) begin
      prev = 32'(slot_rd.start);
    end else begin
      prev = smrs_pkg::NO_RECORD;
    end
  end

  // Sequencer next state and memory controls
  always_comb begin
    state_d      = state_q;
    slot_d       = slot_q;
    len_d        = len_q;
    data_d       = data_q;
    wp_d         = wp_q;
    put_open_d   = put_open_q;
    hdr_d        = hdr_q;
    cnt_d        = cnt_q;
    seq_d        = seq_q;
    stored_d     = stored_q;
    cur_d        = cur_q;
    n_d          = n_q;
    slot_valid_d = slot_valid_q;

    slot_raddr = (state_q == ST_IDLE) ? in_slot : slot_q;
    slot_we    = 1'b0;
    slot_wdata = '{seq: seq_new, start: (wrap ? '0 : wp_q)};
    ring_we    = 1'b0;
    ring_waddr = wp_q;
    ring_wdata = in_data;
    ring_raddr = cur_q;
    ob_push    = 1'b0;
    ob_item    = '{status: smrs_pkg::STATUS_OK, read_byte: ring_rdata, last: fin};

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_opcode == smrs_pkg::OP_GET) begin
            slot_d  = in_slot;
            state_d = ST_GET_SLOT;
          end else if (in_first) begin
            slot_d  = in_slot;
            len_d   = in_len;
            data_d  = in_data;
            state_d = ST_PUT_SLOT;
          end else if (put_open_q) begin
            // Continue an open put: one byte a cycle
            ring_we = 1'b1;
            wp_d    = smrs_pkg::ring_add(wp_q, 3'd1);
            if (in_data == 8'd0) begin
              put_open_d = 1'b0;
            end
          end
        end
      end
      ST_PUT_SLOT: begin
        // Bump the sequence number and place the record
        slot_we              = 1'b1;
        slot_valid_d[slot_q] = 1'b1;
        hdr_d                = {prev, seq_new};
        wp_d                 = wrap ? '0 : wp_q;
        cnt_d                = 3'd0;
        state_d              = ST_PUT_HDR;
      end
      ST_PUT_HDR: begin
        ring_we    = 1'b1;
        ring_wdata = hdr_q[7:0];
        hdr_d      = {8'd0, hdr_q[63:8]};
        wp_d       = smrs_pkg::ring_add(wp_q, 3'd1);
        cnt_d      = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          state_d = ST_PUT_DATA;
        end
      end
      ST_PUT_DATA: begin
        ring_we    = 1'b1;
        ring_wdata = data_q;
        wp_d       = smrs_pkg::ring_add(wp_q, 3'd1);
        put_open_d = (data_q != 8'd0);
        state_d    = ST_IDLE;
      end
      ST_GET_SLOT: begin
        if (!slot_valid_q[slot_q]) begin
          ob_item = '{status: smrs_pkg::STATUS_EMPTY, read_byte: 8'd0, last: 1'b1};
          if (ob_ready) begin
            ob_push = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          // Start reading the stored sequence number
          ring_raddr = slot_rd.start;
          cur_d      = slot_rd.start;
          seq_d      = slot_rd.seq;
          cnt_d      = 3'd0;
          state_d    = ST_GET_SEQ;
        end
      end
      ST_GET_SEQ: begin
        if (cnt_q != 3'd3) begin
          stored_d   = {ring_rdata, stored_q[23:8]};
          ring_raddr = smrs_pkg::ring_add(cur_q, 3'd1);
          cur_d      = ring_raddr;
          cnt_d      = cnt_q + 3'd1;
        end else if (stored_full != seq_q) begin
          // Record overwritten: hold the read and report once
          ob_item = '{status: smrs_pkg::STATUS_STALE, read_byte: 8'd0, last: 1'b1};
          if (ob_ready) begin
            ob_push = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          // Skip the previous pointer field
          ring_raddr = smrs_pkg::ring_add(cur_q, 3'd5);
          cur_d      = ring_raddr;
          n_d        = '0;
          state_d    = ST_GET_MSG;
        end
      end
      ST_GET_MSG: begin
        if (ob_ready) begin
          ob_push = 1'b1;
          n_d     = n_q + smrs_pkg::MSG_CW'(1);
          if (fin) begin
            state_d = ST_IDLE;
          end else begin
            ring_raddr = smrs_pkg::ring_add(cur_q, 3'd1);
            cur_d      = ring_raddr;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state and registered control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      wp_q         <= '0;
      put_open_q   <= 1'b0;
      slot_valid_q <= '0;
      slot_q       <= '0;
      len_q        <= '0;
      data_q       <= '0;
      hdr_q        <= '0;
      cnt_q        <= '0;
      seq_q        <= '0;
      stored_q     <= '0;
      cur_q        <= '0;
      n_q          <= '0;
    end else begin
      state_q      <= state_d;
      wp_q         <= wp_d;
      put_open_q   <= put_open_d;
      slot_valid_q <= slot_valid_d;
      slot_q       <= slot_d;
      len_q        <= len_d;
      data_q       <= data_d;
      hdr_q        <= hdr_d;
      cnt_q        <= cnt_d;
      seq_q        <= seq_d;
      stored_q     <= stored_d;
      cur_q        <= cur_d;
      n_q          <= n_d;
    end
  end

  // Slot table: sequence number and record start per slot
  smrs_ram #(
    .DEPTH (smrs_pkg::NUM_SLOTS),
    .WIDTH ($bits(smrs_pkg::slot_entry_t))
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_q),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  // Shared byte ring
  smrs_ram #(
    .DEPTH (smrs_pkg::RING_BYTES),
    .WIDTH (8)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  // Result buffer toward the sink
  smrs_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ob_push),
    .item_i  (ob_item),
    .ready_o (ob_ready),
    .valid_o (m_axis_tvalid_o),
    .pop_i   (m_axis_tready_i),
    .item_o  (ob_head)
  );

  assign m_axis_tdata_o = ob_head.read_byte;
  assign m_axis_tuser_o = ob_head.status;
  assign m_axis_tlast_o = ob_head.last;

  // Error status always closes the get
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != smrs_pkg::STATUS_OK)) |-> m_axis_tlast_o)
    else $error("error status without last");

  // Ring is never written while a get streams
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_we |-> !get_active)
    else $error("ring write during get");

  // Results are only pushed when the buffer has room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ob_push |-> ob_ready)
    else $error("push into full output buffer");

  // Opening a record marks its slot valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUT_SLOT) |=> slot_valid_q[slot_q])
    else $error("slot not valid after put start");

endmodule
